[rtl/core/dnv_pkg.sv]
package dnv_pkg;

    // Character codes the rules care about
    localparam logic [7:0] CHAR_DOT  = 8'h2E;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    // A segment needs at least this many bytes; the counter saturates here
    localparam logic [1:0] SEG_MIN = 2'd3;

    // Total length saturates here, above any legal max_length
    localparam logic [8:0] TOTAL_CAP = 9'd511;

    // Register indexes (word address bit)
    localparam logic REG_MIN_LENGTH = 1'b0;
    localparam logic REG_MAX_LENGTH = 1'b1;

    typedef struct packed {
        logic [7:0] min_length;
        logic [7:0] max_length;
    } dnv_cfg_t;

    function automatic logic is_lower(input logic [7:0] c);
        is_lower = (c inside {[8'h61:8'h7A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c inside {[8'h30:8'h39]});
    endfunction

endpackage

[rtl/core/dnv_cfg.sv]
module dnv_cfg
    import dnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output dnv_cfg_t    cfg
);

    logic [7:0] min_length_reg;
    logic [7:0] max_length_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Byte offset bits are ignored; paddr[2] selects the register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= 8'd3;
            max_length_reg <= 8'd16;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_MIN_LENGTH)
            begin
                min_length_reg <= pwdata[7:0];
            end
            else
            begin
                max_length_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_MIN_LENGTH)
        begin
            prdata = {24'd0, min_length_reg};
        end
        else
        begin
            prdata = {24'd0, max_length_reg};
        end
    end

    assign cfg.min_length = min_length_reg;
    assign cfg.max_length = max_length_reg;

endmodule

[rtl/core/dnv_check.sv]
module dnv_check
    import dnv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_byte,
    input  logic       last_byte,
    input  dnv_cfg_t   cfg,
    output logic       name_valid
);

    logic [1:0] seg_len_reg;
    logic [1:0] seg_len_next;
    logic       prev_alnum_reg;
    logic       prev_alnum_next;
    logic       still_ok_reg;
    logic       still_ok_next;
    logic [8:0] total_reg;
    logic [8:0] total_next;

    logic [8:0] total_inc;
    logic [1:0] seg_a;
    logic       prev_a;
    logic       ok_a;
    logic       ok_f;
    logic       alnum;
    logic       bad;

    always_comb
    begin
        total_inc = (total_reg == TOTAL_CAP) ? TOTAL_CAP : total_reg + 9'd1;
        alnum     = is_lower(char_byte) || is_digit(char_byte);
        bad       = 1'b0;
        if (char_byte == CHAR_DOT)
        begin
            // dot closes the segment
            ok_a   = still_ok_reg && (seg_len_reg == SEG_MIN) && prev_alnum_reg;
            seg_a  = 2'd0;
            prev_a = 1'b0;
        end
        else
        begin
            if (seg_len_reg == 2'd0)
            begin
                bad = !is_lower(char_byte);
            end
            else
            begin
                bad = !alnum && (char_byte != CHAR_DASH);
            end
            ok_a   = still_ok_reg && !bad;
            seg_a  = (seg_len_reg == SEG_MIN) ? SEG_MIN : seg_len_reg + 2'd1;
            prev_a = alnum;
        end

        // closing the final segment and checking the length bounds
        ok_f       = ok_a && (seg_a == SEG_MIN) && prev_a;
        name_valid = ok_f && (total_inc >= {1'b0, cfg.min_length})
                          && (total_inc <= {1'b0, cfg.max_length});

        if (last_byte)
        begin
            seg_len_next    = 2'd0;
            prev_alnum_next = 1'b0;
            still_ok_next   = 1'b1;
            total_next      = 9'd0;
        end
        else
        begin
            seg_len_next    = seg_a;
            prev_alnum_next = prev_a;
            still_ok_next   = ok_a;
            total_next      = total_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg    <= 2'd0;
            prev_alnum_reg <= 1'b0;
            still_ok_reg   <= 1'b1;
            total_reg      <= 9'd0;
        end
        else if (step)
        begin
            seg_len_reg    <= seg_len_next;
            prev_alnum_reg <= prev_alnum_next;
            still_ok_reg   <= still_ok_next;
            total_reg      <= total_next;
        end
    end

endmodule

[rtl/core/dotted_name_validator.sv]
// dotted_name_validator: checks a dotted name, one byte per request.
// The verdict is registered as the final byte leaves the input register.
// Throughput: one byte per cycle; input stalls only while a final byte waits
// behind a verdict that the sink has not yet taken.
// Reset (rst_n, async, active low): pipeline empty, name state cleared,
// min_length = 3, max_length = 16.
module dotted_name_validator
    import dnv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // APB-style register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // byte stream in
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        last_byte,

    // verdict out
    output logic        out_valid,
    input  logic        out_stall,
    output logic        name_valid
);

    dnv_cfg_t   cfg;

    // input register
    logic       s1_valid_reg;
    logic       s1_valid_next;
    logic [7:0] s1_char_reg;
    logic       s1_last_reg;

    // output register
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       name_valid_reg;

    logic       verdict;
    logic       advance;
    logic       in_take;

    dnv_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Name state only moves when the held byte leaves the input register.
    dnv_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .char_byte  (s1_char_reg),
        .last_byte  (s1_last_reg),
        .cfg        (cfg),
        .name_valid (verdict)
    );

    // A non-final byte produces no verdict, so it always moves on. A final
    // byte needs the output register free, or being emptied this cycle.
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = in_take || (s1_valid_reg && !advance);

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_byte;
            s1_last_reg <= last_byte;
        end
        if (advance && s1_last_reg)
        begin
            name_valid_reg <= verdict;
        end
    end

    assign out_valid  = out_valid_reg;
    assign name_valid = name_valid_reg;

endmodule
